>>> sv/cjme_pkg.sv
// Shared types and constants for the card job machine executor.
package cjme_pkg;

    localparam int MEM_WORDS_DEF   = 100;
    localparam int BLOCK_WORDS_DEF = 10;
    localparam int PTR_W           = 7;
    localparam int CNT_W           = 4;

    localparam logic [2:0] OP_NEW   = 3'd0;
    localparam logic [2:0] OP_PROG  = 3'd1;
    localparam logic [2:0] OP_START = 3'd2;
    localparam logic [2:0] OP_STEP  = 3'd3;
    localparam logic [2:0] OP_DATA  = 3'd4;

    localparam logic [2:0] ST_OK   = 3'd0;
    localparam logic [2:0] ST_NEED = 3'd1;
    localparam logic [2:0] ST_OUT  = 3'd2;
    localparam logic [2:0] ST_HALT = 3'd3;
    localparam logic [2:0] ST_ADDR = 3'd4;
    localparam logic [2:0] ST_NRDY = 3'd5;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_RUN  = 2'd1;
    localparam logic [1:0] MODE_WAIT = 2'd2;
    localparam logic [1:0] MODE_HALT = 2'd3;

    localparam logic [7:0] CH_G = 8'h47;
    localparam logic [7:0] CH_P = 8'h50;
    localparam logic [7:0] CH_H = 8'h48;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_S = 8'h53;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_B = 8'h42;
    localparam logic [7:0] CH_T = 8'h54;
    localparam logic [7:0] CH_R = 8'h52;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_0 = 8'h30;
    localparam logic [7:0] CH_9 = 8'h39;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] word;
    } t_in;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] out_word;
        logic        last;
    } t_out;

endpackage

>>> sv/card_job_machine_executor.sv
// Card job machine executor: word machine with sequencer and two-port word memory.
// Non-step transactions give their result the cycle after acceptance, busy stays low.
// Step: fetch on acceptance, then S_DECODE registers the result; LR and CR via S_EXEC.
// PD: S_PD_RD and S_PD_OUT alternate for each output word, BLOCK_WORDS words in all.
// The registered memory read port sets this sequence; results cannot be stalled by the receiver.
// Reset (synchronous, active low) empties memory by clearing the per-word valid bits.
module card_job_machine_executor
    import cjme_pkg::*;
#(
    parameter int MEM_WORDS   = MEM_WORDS_DEF,
    parameter int BLOCK_WORDS = BLOCK_WORDS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_in  i_item,
    output logic o_busy,
    output logic o_strobe,
    output t_out o_result
);

    localparam int AW = $clog2(MEM_WORDS);
    localparam logic [7:0]       MEM_N    = 8'(MEM_WORDS);
    localparam logic [CNT_W-1:0] BLK_N    = CNT_W'(BLOCK_WORDS);
    localparam logic [CNT_W-1:0] BLK_LAST = CNT_W'(BLOCK_WORDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_EXEC,
        S_PD_RD,
        S_PD_OUT
    } t_state;

    t_state r_state, n_state;
    logic [1:0]       r_mode, n_mode;
    logic [PTR_W-1:0] r_ic, n_ic;
    logic [31:0]      r_gr, n_gr;
    logic             r_tog, n_tog;
    logic [PTR_W-1:0] r_lp, n_lp;
    logic [PTR_W-1:0] r_db, n_db;
    logic [CNT_W-1:0] r_dc, n_dc;
    logic [PTR_W-1:0] r_base, n_base;
    logic [CNT_W-1:0] r_k, n_k;
    logic             r_is_load, n_is_load;
    logic             r_strobe, n_strobe;
    t_out             r_out, n_out;

    logic [31:0] r_mem [MEM_WORDS];
    logic [MEM_WORDS-1:0] r_valid;
    logic [31:0] r_rd_data;
    logic        r_rd_valid;

    logic          mem_we;
    logic          mem_clr;
    logic [AW-1:0] mem_waddr;
    logic [31:0]   mem_wdata;
    logic [AW-1:0] rd_addr;

    logic [31:0] ir;
    logic [31:0] rd_word;
    logic [7:0]  c0, c1, c2, c3;
    logic        dig2, dig3;
    logic [3:0]  d2, d3;
    logic [PTR_W-1:0] addr2, bbase;
    logic        a2_ok, b_ok;
    logic [7:0]  pd_sum;
    logic [7:0]  dw_addr;
    logic [CNT_W-1:0] dc_inc;

    assign rd_word = r_rd_valid ? r_rd_data : 32'd0;
    assign ir      = rd_word;
    assign c0 = ir[31:24];
    assign c1 = ir[23:16];
    assign c2 = ir[15:8];
    assign c3 = ir[7:0];
    assign dig2 = (c2 >= CH_0) && (c2 <= CH_9);
    assign dig3 = (c3 >= CH_0) && (c3 <= CH_9);
    assign d2 = 4'(c2 - CH_0);
    assign d3 = 4'(c3 - CH_0);
    assign bbase = PTR_W'({3'b0, d2} << 3) + PTR_W'({3'b0, d2} << 1);
    assign addr2 = bbase + PTR_W'(d3);
    assign b_ok  = dig2 && ({1'b0, bbase} < MEM_N);
    assign a2_ok = dig2 && dig3 && ({1'b0, addr2} < MEM_N);
    assign pd_sum  = {1'b0, r_base} + {4'b0, r_k};
    assign dw_addr = {1'b0, r_db} + {4'b0, r_dc};
    assign dc_inc  = r_dc + CNT_W'(1);

    always_comb begin
        n_state   = r_state;
        n_mode    = r_mode;
        n_ic      = r_ic;
        n_gr      = r_gr;
        n_tog     = r_tog;
        n_lp      = r_lp;
        n_db      = r_db;
        n_dc      = r_dc;
        n_base    = r_base;
        n_k       = r_k;
        n_is_load = r_is_load;
        n_strobe  = 1'b0;
        n_out     = '0;
        n_out.last = 1'b1;
        mem_we    = 1'b0;
        mem_clr   = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        rd_addr   = r_ic[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_strobe = 1'b1;
                    n_out.status = ST_OK;
                    case (i_item.opcode)
                        OP_NEW: begin
                            mem_clr = 1'b1;
                            n_mode  = MODE_IDLE;
                            n_ic    = '0;
                            n_gr    = '0;
                            n_tog   = 1'b0;
                            n_lp    = '0;
                            n_db    = '0;
                            n_dc    = '0;
                        end
                        OP_PROG: begin
                            if ({1'b0, r_lp} < MEM_N) begin
                                mem_we    = 1'b1;
                                mem_waddr = r_lp[AW-1:0];
                                mem_wdata = i_item.word;
                                n_lp      = r_lp + PTR_W'(1);
                            end
                        end
                        OP_START: begin
                            n_ic   = '0;
                            n_mode = MODE_RUN;
                        end
                        OP_STEP: begin
                            if (r_mode == MODE_IDLE || r_mode == MODE_HALT) begin
                                n_out.status = ST_NRDY;
                            end else if (r_mode == MODE_WAIT) begin
                                n_out.status = ST_NEED;
                            end else if ({1'b0, r_ic} >= MEM_N) begin
                                n_out.status = ST_ADDR;
                                n_mode       = MODE_HALT;
                            end else begin
                                n_strobe = 1'b0;
                                n_ic     = r_ic + PTR_W'(1);
                                n_state  = S_DECODE;
                            end
                        end
                        OP_DATA: begin
                            if (r_mode != MODE_WAIT) begin
                                n_out.status = ST_NRDY;
                            end else begin
                                if (dw_addr < MEM_N) begin
                                    mem_we    = 1'b1;
                                    mem_waddr = dw_addr[AW-1:0];
                                    mem_wdata = i_item.word;
                                end
                                n_dc = dc_inc;
                                if (dc_inc >= BLK_N) begin
                                    n_mode = MODE_RUN;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_DECODE: begin
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
                n_out.status = ST_OK;
                rd_addr      = addr2[AW-1:0];
                if (c0 == CH_G && c1 == CH_D) begin
                    if (!b_ok) begin
                        n_out.status = ST_ADDR;
                    end else begin
                        n_db         = bbase;
                        n_dc         = '0;
                        n_mode       = MODE_WAIT;
                        n_out.status = ST_NEED;
                    end
                end else if (c0 == CH_P && c1 == CH_D) begin
                    if (!b_ok) begin
                        n_out.status = ST_ADDR;
                    end else begin
                        n_strobe = 1'b0;
                        n_base   = bbase;
                        n_k      = '0;
                        n_state  = S_PD_RD;
                    end
                end else if (c0 == CH_H) begin
                    n_mode       = MODE_HALT;
                    n_out.status = ST_HALT;
                end else if (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) begin
                    if (!a2_ok) begin
                        n_out.status = ST_ADDR;
                    end else if (c0 == CH_S) begin
                        mem_we    = 1'b1;
                        mem_waddr = addr2[AW-1:0];
                        mem_wdata = r_gr;
                    end else begin
                        n_strobe  = 1'b0;
                        n_is_load = (c0 == CH_L);
                        n_state   = S_EXEC;
                    end
                end else if (c0 == CH_B && c1 == CH_T) begin
                    if (r_tog) begin
                        if (!a2_ok) begin
                            n_out.status = ST_ADDR;
                        end else begin
                            n_ic = addr2;
                        end
                    end
                end
            end
            S_EXEC: begin
                n_strobe     = 1'b1;
                n_state      = S_IDLE;
                n_out.status = ST_OK;
                if (r_is_load) begin
                    n_gr = rd_word;
                end else begin
                    n_tog = (rd_word == r_gr);
                end
            end
            S_PD_RD: begin
                rd_addr = pd_sum[AW-1:0];
                n_state = S_PD_OUT;
            end
            S_PD_OUT: begin
                rd_addr        = pd_sum[AW-1:0];
                n_strobe       = 1'b1;
                n_out.status   = ST_OUT;
                n_out.out_word = (pd_sum < MEM_N) ? rd_word : 32'd0;
                n_out.last     = (r_k == BLK_LAST);
                n_k            = r_k + CNT_W'(1);
                n_state        = (r_k == BLK_LAST) ? S_IDLE : S_PD_RD;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_mode    <= MODE_IDLE;
            r_ic      <= '0;
            r_gr      <= '0;
            r_tog     <= 1'b0;
            r_lp      <= '0;
            r_db      <= '0;
            r_dc      <= '0;
            r_base    <= '0;
            r_k       <= '0;
            r_is_load <= 1'b0;
            r_strobe  <= 1'b0;
            r_out     <= '0;
        end else begin
            r_state   <= n_state;
            r_mode    <= n_mode;
            r_ic      <= n_ic;
            r_gr      <= n_gr;
            r_tog     <= n_tog;
            r_lp      <= n_lp;
            r_db      <= n_db;
            r_dc      <= n_dc;
            r_base    <= n_base;
            r_k       <= n_k;
            r_is_load <= n_is_load;
            r_strobe  <= n_strobe;
            r_out     <= n_out;
        end
    end

    // word memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // per-word valid bits; an unwritten word reads as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || mem_clr) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (mem_we) begin
                r_valid[mem_waddr] <= 1'b1;
            end
            r_rd_valid <= r_valid[rd_addr];
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_result = r_out;

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_result.status <= ST_NRDY))
        else $error("status code out of range");

    a_word_only_pd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_result.status != ST_OUT) |-> (o_result.out_word == 32'd0))
        else $error("nonzero word outside PD");

    a_pd_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PD_OUT) |=> (o_strobe && o_result.status == ST_OUT))
        else $error("PD word not emitted");

    a_simple_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.opcode != OP_STEP) |=> (o_strobe && o_result.last))
        else $error("transaction without final result");

endmodule

>>> verif/tb_card_job_machine_executor.sv
// Self-checking testbench for the card job machine executor: directed jobs, random jobs, scoreboard.
module tb_card_job_machine_executor;
    import cjme_pkg::*;

    localparam int         CLK_PERIOD   = 8;
    localparam int         TAIL_CYCLES  = 40;
    localparam int         REPORT_LIMIT = 10;
    localparam logic [2:0] OP_UNDEF_LO  = 3'd5;
    localparam logic [2:0] OP_UNDEF_HI  = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_in  i_item;
    logic o_busy;
    logic o_strobe;
    t_out o_result;

    card_job_machine_executor dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_item   (i_item),
        .o_busy   (o_busy),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    // machine image kept by the predictor
    logic [31:0]      job_mem [0:MEM_WORDS_DEF-1];
    logic [PTR_W-1:0] job_ic;
    logic [31:0]      job_acc;
    logic             job_flag;
    logic [PTR_W-1:0] load_ptr;
    logic [1:0]       run_state;
    logic [PTR_W-1:0] block_base;
    logic [CNT_W-1:0] block_fill;

    t_out awaited_results [$];
    int   mismatch_count;
    int   items_sent;
    int   idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    initial begin
        #(CLK_PERIOD * 300000);
        $display("status: fail");
        $finish;
    end

    task automatic clear_job_model();
        for (int i = 0; i < MEM_WORDS_DEF; i++) begin
            job_mem[i] = '0;
        end
        job_ic     = '0;
        job_acc    = '0;
        job_flag   = 1'b0;
        load_ptr   = '0;
        run_state  = MODE_IDLE;
        block_base = '0;
        block_fill = '0;
    endtask

    task automatic push_result(input logic [2:0] st, input logic [31:0] w, input logic lst);
        t_out r;
        r.status   = st;
        r.out_word = w;
        r.last     = lst;
        awaited_results.push_back(r);
    endtask

    function automatic bit dec_char(input logic [7:0] c);
        return (c >= CH_0) && (c <= CH_9);
    endfunction

    task automatic execute_step();
        logic [31:0] ir;
        logic [7:0]  c0, c1, c2, c3;
        int          pair_addr;
        int          base;
        bit          pair_ok;
        bit          base_ok;
        if (run_state == MODE_IDLE || run_state == MODE_HALT) begin
            push_result(ST_NRDY, '0, 1'b1);
        end else if (run_state == MODE_WAIT) begin
            push_result(ST_NEED, '0, 1'b1);
        end else if (job_ic >= MEM_WORDS_DEF) begin
            run_state = MODE_HALT;
            push_result(ST_ADDR, '0, 1'b1);
        end else begin
            ir = job_mem[job_ic];
            job_ic = job_ic + 1'b1;
            {c0, c1, c2, c3} = ir;
            pair_addr = (int'(c2) - int'(CH_0)) * 10 + (int'(c3) - int'(CH_0));
            pair_ok   = dec_char(c2) && dec_char(c3) && (pair_addr < MEM_WORDS_DEF);
            base      = (int'(c2) - int'(CH_0)) * 10;
            base_ok   = dec_char(c2) && (base < MEM_WORDS_DEF);
            if (c0 == CH_G && c1 == CH_D) begin
                if (!base_ok) begin
                    push_result(ST_ADDR, '0, 1'b1);
                end else begin
                    block_base = 7'(base);
                    block_fill = '0;
                    run_state  = MODE_WAIT;
                    push_result(ST_NEED, '0, 1'b1);
                end
            end else if (c0 == CH_P && c1 == CH_D) begin
                if (!base_ok) begin
                    push_result(ST_ADDR, '0, 1'b1);
                end else begin
                    for (int k = 0; k < BLOCK_WORDS_DEF; k++) begin
                        push_result(ST_OUT,
                                    (base + k < MEM_WORDS_DEF) ? job_mem[base + k] : 32'h0,
                                    k == BLOCK_WORDS_DEF - 1);
                    end
                end
            end else if (c0 == CH_H) begin
                run_state = MODE_HALT;
                push_result(ST_HALT, '0, 1'b1);
            end else if (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) begin
                if (!pair_ok) begin
                    push_result(ST_ADDR, '0, 1'b1);
                end else begin
                    if (c0 == CH_L) begin
                        job_acc = job_mem[pair_addr];
                    end else if (c0 == CH_S) begin
                        job_mem[pair_addr] = job_acc;
                    end else begin
                        job_flag = (job_mem[pair_addr] == job_acc);
                    end
                    push_result(ST_OK, '0, 1'b1);
                end
            end else if (c0 == CH_B && c1 == CH_T && job_flag) begin
                if (!pair_ok) begin
                    push_result(ST_ADDR, '0, 1'b1);
                end else begin
                    job_ic = 7'(pair_addr);
                    push_result(ST_OK, '0, 1'b1);
                end
            end else begin
                push_result(ST_OK, '0, 1'b1);
            end
        end
    endtask

    task automatic execute_item(input t_in it);
        int a;
        case (it.opcode)
            OP_NEW: begin
                clear_job_model();
                push_result(ST_OK, '0, 1'b1);
            end
            OP_PROG: begin
                if (load_ptr < MEM_WORDS_DEF) begin
                    job_mem[load_ptr] = it.word;
                    load_ptr = load_ptr + 1'b1;
                end
                push_result(ST_OK, '0, 1'b1);
            end
            OP_START: begin
                job_ic    = '0;
                run_state = MODE_RUN;
                push_result(ST_OK, '0, 1'b1);
            end
            OP_STEP: begin
                execute_step();
            end
            OP_DATA: begin
                if (run_state != MODE_WAIT) begin
                    push_result(ST_NRDY, '0, 1'b1);
                end else begin
                    a = int'(block_base) + int'(block_fill);
                    if (a < MEM_WORDS_DEF) begin
                        job_mem[a] = it.word;
                    end
                    block_fill = block_fill + 1'b1;
                    if (block_fill >= BLOCK_WORDS_DEF) begin
                        run_state = MODE_RUN;
                    end
                    push_result(ST_OK, '0, 1'b1);
                end
            end
            default: begin
                push_result(ST_OK, '0, 1'b1);
            end
        endcase
    endtask

    task automatic check_result(input t_out got);
        t_out want;
        if (awaited_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT) begin
                $display("unexpected result at %0t: st=%0d word=%h last=%b",
                         $time, got.status, got.out_word, got.last);
            end
        end else begin
            want = awaited_results.pop_front();
            if (got.status !== want.status || got.out_word !== want.out_word ||
                got.last !== want.last) begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT) begin
                    $display("mismatch at %0t: got %0d/%h/%b, exp %0d/%h/%b",
                             $time, got.status, got.out_word, got.last,
                             want.status, want.out_word, want.last);
                end
            end
        end
    endtask

    // results first, then the transaction accepted at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_strobe) begin
                check_result(o_result);
            end
            if (i_start && !o_busy) begin
                execute_item(i_item);
            end
        end
    end

    task automatic send_item(input logic [2:0] op, input logic [31:0] w);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        i_item  = {op, w};
        i_start = 1'b1;
        forever begin
            @(posedge i_clk);
            if (!o_busy) break;
        end
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic finish_outstanding();
        i_start = 1'b0;
        while (awaited_results.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] rand_word();
        int r;
        r = $urandom_range(0, 7);
        if (r == 0) return 32'h0;
        if (r == 1) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [7:0] rand_addr_char();
        int r;
        r = $urandom_range(0, 15);
        if (r < 8) return CH_0 + 8'($urandom_range(0, 2));
        if (r < 13) return CH_0 + 8'($urandom_range(0, 9));
        if (r == 13) return CH_0 - 8'd1;
        if (r == 14) return CH_9 + 8'd1;
        return 8'($urandom);
    endfunction

    function automatic logic [31:0] gen_instr();
        logic [7:0] d2, d3, tail;
        int         k;
        d2   = rand_addr_char();
        d3   = rand_addr_char();
        tail = 8'($urandom);
        k    = $urandom_range(0, 15);
        case (k)
            0, 1:    return {CH_G, CH_D, d2, tail};
            2, 3:    return {CH_P, CH_D, d2, tail};
            4, 5:    return {CH_L, CH_R, d2, d3};
            6, 7:    return {CH_S, CH_R, d2, d3};
            8, 9:    return {CH_C, CH_R, d2, d3};
            10, 11:  return {CH_B, CH_T, d2, d3};
            12:      return {CH_H, 24'($urandom)};
            13:      return {8'($urandom), CH_R, d2, d3};
            default: return $urandom;
        endcase
    endfunction

    task automatic run_job_steps(input int max_steps);
        int r;
        int left;
        for (int n = 0; n < max_steps; n++) begin
            if (run_state == MODE_HALT || run_state == MODE_IDLE) begin
                if ($urandom_range(0, 3) == 0) send_item(OP_STEP, $urandom);
                break;
            end
            r = $urandom_range(0, 31);
            if (run_state == MODE_WAIT) begin
                if (r == 0) begin
                    send_item(OP_STEP, $urandom);
                end else if (r == 1) begin
                    send_item(OP_START, $urandom);
                end else begin
                    left = BLOCK_WORDS_DEF - int'(block_fill);
                    if (r < 5) left = $urandom_range(1, left);
                    repeat (left) send_item(OP_DATA, rand_word());
                end
            end else if (r == 0) begin
                send_item(OP_PROG, gen_instr());
            end else if (r == 1) begin
                send_item(OP_DATA, rand_word());
            end else if (r == 2) begin
                send_item(3'($urandom_range(OP_UNDEF_LO, OP_UNDEF_HI)), $urandom);
            end else begin
                send_item(OP_STEP, $urandom);
            end
        end
    endtask

    task automatic test_job_flow();
        idle_pct = 0;
        send_item(OP_STEP, '0);
        send_item(OP_UNDEF_HI, 32'hFFFF_FFFF);
        send_item(OP_NEW, '0);
        send_item(OP_PROG, "GD1:");
        send_item(OP_PROG, "PD1/");
        send_item(OP_PROG, "CR42");
        send_item(OP_PROG, "BT99");
        send_item(OP_START, '0);
        send_item(OP_STEP, '0);
        send_item(OP_STEP, '0);
        send_item(OP_START, '0);
        send_item(OP_STEP, '0);
        for (int k = 0; k < BLOCK_WORDS_DEF; k++) begin
            send_item(OP_DATA, (k == 0) ? 32'h0 :
                               (k == BLOCK_WORDS_DEF - 1) ? 32'hFFFF_FFFF : $urandom);
        end
        repeat (6) send_item(OP_STEP, '0);
        finish_outstanding();
    endtask

    task automatic test_special_cases();
        idle_pct = 0;
        send_item(OP_NEW, '0);
        send_item(OP_PROG, "BT/:");
        send_item(OP_PROG, "LR:0");
        send_item(OP_PROG, "LR01");
        send_item(OP_PROG, "SR20");
        send_item(OP_PROG, "CR20");
        send_item(OP_PROG, "BT9/");
        send_item(OP_PROG, "HLT!");
        send_item(OP_START, '0);
        send_item(OP_PROG, "PD2 ");
        repeat (7) send_item(OP_STEP, '0);
        send_item(OP_DATA, 32'hA5A5_5A5A);
        finish_outstanding();
    endtask

    task automatic test_memory_full();
        idle_pct = 52;
        send_item(OP_NEW, '0);
        repeat (MEM_WORDS_DEF + 3) send_item(OP_PROG, gen_instr());
        send_item(OP_START, '0);
        run_job_steps(4);
        finish_outstanding();
    endtask

    task automatic test_random_jobs(input int goal, input int pct);
        int target;
        idle_pct = pct;
        target   = items_sent + goal;
        while (items_sent < target) begin
            if ($urandom_range(0, 7) != 0) send_item(OP_NEW, $urandom);
            repeat ($urandom_range(2, 10)) send_item(OP_PROG, gen_instr());
            if ($urandom_range(0, 1) == 0) send_item(OP_PROG, {CH_H, 24'($urandom)});
            send_item(OP_START, $urandom);
            run_job_steps(8);
        end
        finish_outstanding();
    endtask

    initial begin
        i_rst_n        = 1'b0;
        i_start        = 1'b0;
        i_item         = '0;
        mismatch_count = 0;
        items_sent     = 0;
        idle_pct       = 0;
        clear_job_model();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_job_flow();
        test_special_cases();
        test_memory_full();
        test_random_jobs(8, 0);
        test_random_jobs(8, 52);
        test_random_jobs(8, 23);

        finish_outstanding();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && awaited_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

>>> sim.f
sv/cjme_pkg.sv
sv/card_job_machine_executor.sv
verif/tb_card_job_machine_executor.sv
